// ----- design/prc_pkg.sv -----
// Package for the polygon rectangle clipper.
// Holds shared constants and configuration register indexes; no dependencies.
package prc_pkg;

   // Default coordinate width (Q16.16 fixed point).
   localparam int COORD_WIDTH_DEF = 32;

   // Width of the fixed coordinate fields on the stream ports.
   localparam int PORT_COORD_W = 32;

   // Configuration register index width and the register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_X_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_MIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_MAX = 2'd3;

endpackage

// ----- design/prc_cell.sv -----
// One clipping cell: tests vertices against a single rectangle edge and emits
// the clipped edge list. Depends on prc_pkg.
module prc_cell import prc_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter bit AXIS_Y      = 1'b0,
   parameter bit IS_MAX      = 1'b0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [COORD_WIDTH-1:0] bound,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic                          in_close,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] out_x,
   output logic signed [COORD_WIDTH-1:0] out_y,
   output logic                          out_close
);

   localparam int W  = COORD_WIDTH;
   localparam int CW = $clog2(2 * W);
   localparam logic [CW-1:0] CNT_LAST = CW'(2 * W - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_CROSS, ST_END, ST_CLOSE
   } state_type;

   state_type           state_ff, state_in;
   logic signed [W-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                prev_in_ff, prev_in_in, has_first_ff, has_first_in;
   logic signed [W-1:0] a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic signed [W-1:0] b_x_ff, b_x_in, b_y_ff, b_y_in;
   logic                need_b_ff, need_b_in;
   logic                need_close_ff, need_close_in;
   logic [W:0]          rem_ff, rem_in;
   logic [2*W-1:0]      quo_ff, quo_in;
   logic [W-1:0]        dvs_ff, dvs_in;
   logic                neg_ff, neg_in, zero_ff, zero_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in, out_close_ff, out_close_in;
   logic signed [W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;

   // Inside test against this cell's boundary, bounds inclusive.
   function automatic logic inside_f(logic signed [W-1:0] x, logic signed [W-1:0] y,
                                     logic signed [W-1:0] bnd);
      logic signed [W-1:0] c;
      c = AXIS_Y ? y : x;
      return IS_MAX ? (c <= bnd) : (c >= bnd);
   endfunction

   // Magnitude of a signed difference; it always fits in W bits.
   function automatic logic [W-1:0] mag_f(logic signed [W:0] v);
      logic [W:0] m;
      m = v[W] ? (~v + 1'b1) : v;
      return m[W-1:0];
   endfunction

   logic                pt_in, first_in, slot_free;
   logic signed [W-1:0] along0, along1, across0, across1, cross_val;
   logic signed [W:0]   da, dn, dd;
   logic [W-1:0]        q;
   logic [W:0]          rem_sh;

   assign pt_in     = inside_f(in_x, in_y, bound);
   assign first_in  = inside_f(first_x_ff, first_y_ff, bound);
   assign slot_free = ~out_valid_ff | out_ready;
   assign in_ready  = (state_ff == ST_IDLE);

   // The interpolated coordinate runs along the boundary; the other one crosses it.
   assign along0  = AXIS_Y ? a_x_ff : a_y_ff;
   assign along1  = AXIS_Y ? b_x_ff : b_y_ff;
   assign across0 = AXIS_Y ? a_y_ff : a_x_ff;
   assign across1 = AXIS_Y ? b_y_ff : b_x_ff;
   assign da = {along1[W-1], along1} - {along0[W-1], along0};
   assign dn = {bound[W-1], bound} - {across0[W-1], across0};
   assign dd = {across1[W-1], across1} - {across0[W-1], across0};

   // Restoring division step and the final crossing coordinate.
   assign rem_sh    = {rem_ff[W-1:0], quo_ff[2*W-1]};
   assign q         = quo_ff[W-1:0];
   assign cross_val = zero_ff ? along0 : (neg_ff ? along0 - $signed(q) : along0 + $signed(q));

   // Next-state logic for the cell.
   always_comb begin
      logic edge_ok, ina, inb, need_cross;
      state_in      = state_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_in_in    = prev_in_ff;
      has_first_in  = has_first_ff;
      a_x_in        = a_x_ff;
      a_y_in        = a_y_ff;
      b_x_in        = b_x_ff;
      b_y_in        = b_y_ff;
      need_b_in     = need_b_ff;
      need_close_in = need_close_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      cnt_in        = cnt_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_close_in  = out_close_ff;
      out_valid_in  = out_valid_ff & ~out_ready;
      edge_ok       = 1'b0;
      ina           = 1'b0;
      inb           = 1'b0;
      need_cross    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               a_x_in = prev_x_ff;
               a_y_in = prev_y_ff;
               ina    = prev_in_ff;
               if (in_close) begin
                  // Closing edge from the last vertex back to the first.
                  edge_ok       = has_first_ff;
                  b_x_in        = first_x_ff;
                  b_y_in        = first_y_ff;
                  inb           = first_in;
                  need_close_in = 1'b1;
                  has_first_in  = 1'b0;
                  prev_in_in    = 1'b0;
               end else begin
                  edge_ok       = has_first_ff;
                  b_x_in        = in_x;
                  b_y_in        = in_y;
                  inb           = pt_in;
                  need_close_in = 1'b0;
                  if (!has_first_ff) begin
                     first_x_in = in_x;
                     first_y_in = in_y;
                  end
                  has_first_in = 1'b1;
                  prev_x_in    = in_x;
                  prev_y_in    = in_y;
                  prev_in_in   = pt_in;
               end
               need_cross = edge_ok & (ina ^ inb);
               need_b_in  = edge_ok & inb;
               if (need_cross) begin
                  state_in = ST_MUL;
               end else if (need_b_in) begin
                  state_in = ST_END;
               end else if (need_close_in) begin
                  state_in = ST_CLOSE;
               end
            end
         end
         ST_MUL: begin
            // Product of magnitudes is registered before the divider starts.
            quo_in   = mag_f(da) * mag_f(dn);
            dvs_in   = mag_f(dd);
            neg_in   = da[W] ^ dn[W] ^ dd[W];
            zero_in  = (dd == '0);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh - {1'b0, dvs_ff};
               quo_in = {quo_ff[2*W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[2*W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_CROSS;
            end
         end
         ST_CROSS: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_close_in = 1'b0;
               out_x_in     = AXIS_Y ? cross_val : bound;
               out_y_in     = AXIS_Y ? bound : cross_val;
               if (need_b_ff) begin
                  state_in = ST_END;
               end else if (need_close_ff) begin
                  state_in = ST_CLOSE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_END: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_close_in = 1'b0;
               out_x_in     = b_x_ff;
               out_y_in     = b_y_ff;
               state_in     = need_close_ff ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_close_in = 1'b1;
               out_x_in     = '0;
               out_y_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state is reset; vertex and arithmetic registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         has_first_ff <= 1'b0;
         prev_in_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         has_first_ff <= has_first_in;
         prev_in_ff   <= prev_in_in;
         out_valid_ff <= out_valid_in;
      end
      first_x_ff    <= first_x_in;
      first_y_ff    <= first_y_in;
      prev_x_ff     <= prev_x_in;
      prev_y_ff     <= prev_y_in;
      a_x_ff        <= a_x_in;
      a_y_ff        <= a_y_in;
      b_x_ff        <= b_x_in;
      b_y_ff        <= b_y_in;
      need_b_ff     <= need_b_in;
      need_close_ff <= need_close_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      neg_ff        <= neg_in;
      zero_ff       <= zero_in;
      cnt_ff        <= cnt_in;
      out_x_ff      <= out_x_in;
      out_y_ff      <= out_y_in;
      out_close_ff  <= out_close_in;
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_close = out_close_ff;

endmodule

// ----- design/prc_tail.sv -----
// Output stage: holds back one vertex so the final one can carry the last mark,
// and flags an empty polygon. Depends on prc_pkg.
module prc_tail import prc_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_x,
   input  logic signed [COORD_WIDTH-1:0] in_y,
   input  logic                          in_close,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_x,
   output logic signed [COORD_WIDTH-1:0] rsp_y,
   output logic                          rsp_last,
   output logic                          rsp_empty
);

   logic                          pend_valid_ff, pend_valid_in;
   logic signed [COORD_WIDTH-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                          valid_ff, valid_in, last_ff, last_in, empty_ff, empty_in;
   logic signed [COORD_WIDTH-1:0] x_ff, x_in, y_ff, y_in;

   assign in_ready = ~valid_ff | rsp_ready;

   // Each transaction from the last cell either parks a vertex or releases one.
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      valid_in      = valid_ff & ~rsp_ready;
      last_in       = last_ff;
      empty_in      = empty_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      if (in_valid && in_ready) begin
         if (in_close) begin
            valid_in      = 1'b1;
            last_in       = 1'b1;
            empty_in      = ~pend_valid_ff;
            x_in          = pend_valid_ff ? pend_x_ff : '0;
            y_in          = pend_valid_ff ? pend_y_ff : '0;
            pend_valid_in = 1'b0;
         end else begin
            if (pend_valid_ff) begin
               valid_in = 1'b1;
               last_in  = 1'b0;
               empty_in = 1'b0;
               x_in     = pend_x_ff;
               y_in     = pend_y_ff;
            end
            pend_valid_in = 1'b1;
            pend_x_in     = in_x;
            pend_y_in     = in_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         valid_ff      <= valid_in;
      end
      pend_x_ff <= pend_x_in;
      pend_y_ff <= pend_y_in;
      last_ff   <= last_in;
      empty_ff  <= empty_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_x     = x_ff;
   assign rsp_y     = y_ff;
   assign rsp_last  = last_ff;
   assign rsp_empty = empty_ff;

endmodule

// ----- design/polygon_rect_clipper.sv -----
// Polygon clipper against an axis-aligned rectangle: top level.
// Uses prc_pkg, prc_cell (four clipping cells) and prc_tail.
//
// Vertices enter on the req_ stream, one transaction each, with tlast on the
// final vertex of a polygon. Clipped vertices leave on the rsp_ stream; tlast
// marks the final one and tuser flags an empty result, which comes as a single
// transaction with zero coordinates. The rectangle is written through the csr_
// channel, which is always ready; the user must write it only while no polygon
// work is in flight, as the block does not enforce this. Four cells in a row
// clip against x max, y max, x min and y min, one edge at a time each: an edge
// that keeps nothing is only accepted, one that keeps only its end vertex is
// accepted and output, and one with a crossing is accepted, multiplied, put
// through 2*COORD_WIDTH divider steps and output, then its end vertex if kept.
// req_tready is low while the first cell works or a close marker waits.
// One vertex is held back at the output, so a result appears when the next
// vertex or the end of the polygon reaches the output stage.
// Reset clears all polygon state and loads the widest rectangle. When the
// receiver stalls, results wait in the output registers and the cells fill up
// in turn until req_tready falls.
module polygon_rect_clipper import prc_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2*PORT_COORD_W-1:0] req_tdata,  // vertex_x, vertex_y
   input  logic                    req_tlast,    // vertex_last
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [2*PORT_COORD_W-1:0] rsp_tdata,  // out_x, out_y
   output logic                    rsp_tlast,    // out_last
   output logic                    rsp_tuser,    // out_empty
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [PORT_COORD_W-1:0] csr_wdata
);

   localparam int W = COORD_WIDTH;
   localparam int NCELL = 4;

   logic signed [W-1:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic                close_pend_ff, close_pend_in;

   logic                c_valid [NCELL+1];
   logic                c_ready [NCELL+1];
   logic signed [W-1:0] c_x     [NCELL+1];
   logic signed [W-1:0] c_y     [NCELL+1];
   logic                c_close [NCELL+1];
   logic signed [W-1:0] bnd     [NCELL];
   logic signed [W-1:0] o_x, o_y;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= {1'b1, {(W-1){1'b0}}};
         x_max_ff <= {1'b0, {(W-1){1'b1}}};
         y_min_ff <= {1'b1, {(W-1){1'b0}}};
         y_max_ff <= {1'b0, {(W-1){1'b1}}};
      end else if (csr_valid) begin
         case (csr_index)
            REG_X_MIN: x_min_ff <= csr_wdata[W-1:0];
            REG_X_MAX: x_max_ff <= csr_wdata[W-1:0];
            REG_Y_MIN: y_min_ff <= csr_wdata[W-1:0];
            REG_Y_MAX: y_max_ff <= csr_wdata[W-1:0];
            default: ;
         endcase
      end
   end

   // Feed: a vertex, then a close marker after the final vertex of a polygon.
   assign req_tready = c_ready[0] & ~close_pend_ff;
   assign c_valid[0] = req_tvalid | close_pend_ff;
   assign c_x[0]     = req_tdata[W-1:0];
   assign c_y[0]     = req_tdata[PORT_COORD_W+W-1:PORT_COORD_W];
   assign c_close[0] = close_pend_ff;
   assign close_pend_in = close_pend_ff ? ~c_ready[0]
                                        : (req_tvalid & req_tready & req_tlast);
   always_ff @(posedge clock) begin
      if (reset) begin
         close_pend_ff <= 1'b0;
      end else begin
         close_pend_ff <= close_pend_in;
      end
   end

   assign bnd[0] = x_max_ff;
   assign bnd[1] = y_max_ff;
   assign bnd[2] = x_min_ff;
   assign bnd[3] = y_min_ff;

   // Chain of clipping cells.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      prc_cell #(
         .COORD_WIDTH (W),
         .AXIS_Y      ((i % 2) == 1),
         .IS_MAX      (i < 2)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .bound     (bnd[i]),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_x      (c_x[i]),
         .in_y      (c_y[i]),
         .in_close  (c_close[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_x     (c_x[i+1]),
         .out_y     (c_y[i+1]),
         .out_close (c_close[i+1])
      );
   end

   prc_tail #(
      .COORD_WIDTH (W)
   ) u_tail (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid[NCELL]),
      .in_ready  (c_ready[NCELL]),
      .in_x      (c_x[NCELL]),
      .in_y      (c_y[NCELL]),
      .in_close  (c_close[NCELL]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_x     (o_x),
      .rsp_y     (o_y),
      .rsp_last  (rsp_tlast),
      .rsp_empty (rsp_tuser)
   );

   assign rsp_tdata = {PORT_COORD_W'(o_y), PORT_COORD_W'(o_x)};

endmodule

// ----- tb/polygon_rect_clipper_tb.sv -----
// Self-checking testbench for the polygon rectangle clipper.
// Depends on prc_pkg and the polygon_rect_clipper RTL; predicts clipped polygons itself.
`timescale 1ns / 1ps

module polygon_rect_clipper_tb;
   import prc_pkg::*;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               last;
   } vertex_t;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               last;
      logic               empty;
   } clip_out_t;

   typedef struct {
      logic signed [63:0] x;
      logic signed [63:0] y;
   } point_t;

   localparam int IDLE_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // vertex_x, vertex_y
   logic        req_tlast;   // vertex_last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // out_x, out_y
   logic        rsp_tlast;   // out_last
   logic        rsp_tuser;   // out_empty
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   polygon_rect_clipper DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock generation.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Predictor state: rectangle and per-stage clipping memory.
   logic signed [63:0] rect_x_min, rect_x_max, rect_y_min, rect_y_max;
   point_t stage_first[4];
   point_t stage_prev[4];
   logic   stage_prev_in[4];
   logic   stage_started[4];
   logic   held_valid;
   point_t held_pt;

   vertex_t   pending_vertices[$];
   clip_out_t expected_vertices[$];
   int        error_count;
   int        sent_count;
   int        seen_count;
   int        empty_count;
   int        idle_cycles;
   bit        stimulus_done;
   bit        idle_en;
   bit        hold_off_req;
   int        hold_off_left;

   // Truncating interpolation of the other coordinate at a boundary.
   function automatic logic signed [63:0] interp_coord(input logic signed [63:0] a0,
         input logic signed [63:0] a1, input logic signed [63:0] b0,
         input logic signed [63:0] b1, input logic signed [63:0] bnd);
      logic signed [63:0] da, dn, dd;
      logic [63:0] ma, mn, md;
      logic [63:0] q;
      logic neg;
      da = a1 - a0;
      dn = bnd - b0;
      dd = b1 - b0;
      if (dd == 0) return a0;
      neg = ((da < 0) != (dn < 0)) != (dd < 0);
      ma = (da < 0) ? -da : da;
      mn = (dn < 0) ? -dn : dn;
      md = (dd < 0) ? -dd : dd;
      q = (ma * mn) / md;
      return neg ? a0 - $signed(q) : a0 + $signed(q);
   endfunction

   function automatic logic is_inside(input int s, input point_t p);
      case (s)
         0: return p.x <= rect_x_max;
         1: return p.y <= rect_y_max;
         2: return p.x >= rect_x_min;
         default: return p.y >= rect_y_min;
      endcase
   endfunction

   function automatic point_t crossing_point(input int s, input point_t a, input point_t b);
      point_t c;
      case (s)
         0: begin c.x = rect_x_max; c.y = interp_coord(a.y, b.y, a.x, b.x, rect_x_max); end
         1: begin c.y = rect_y_max; c.x = interp_coord(a.x, b.x, a.y, b.y, rect_y_max); end
         2: begin c.x = rect_x_min; c.y = interp_coord(a.y, b.y, a.x, b.x, rect_x_min); end
         default: begin
            c.y = rect_y_min;
            c.x = interp_coord(a.x, b.x, a.y, b.y, rect_y_min);
         end
      endcase
      return c;
   endfunction

   // One edge of one stage, appending what it keeps.
   task automatic clip_edge(input int s, input point_t a, input logic ina, input point_t b,
         input logic inb, ref point_t lst[$]);
      if (ina && inb) lst.insert(lst.size(), b);
      else if (ina) lst.insert(lst.size(), crossing_point(s, a, b));
      else if (inb) begin
         lst.insert(lst.size(), crossing_point(s, a, b));
         lst.insert(lst.size(), b);
      end
   endtask

   // Works out the clipped vertices that one accepted input vertex releases.
   task automatic predict_clip(input vertex_t v);
      point_t cur[$];
      point_t nxt[$];
      point_t p;
      logic in_now;
      clip_out_t o;
      p.x = v.x;
      p.y = v.y;
      cur.insert(cur.size(), p);
      for (int s = 0; s < 4; s++) begin
         nxt.delete();
         foreach (cur[i]) begin
            in_now = is_inside(s, cur[i]);
            if (!stage_started[s]) begin
               stage_first[s] = cur[i];
               stage_started[s] = 1'b1;
            end else begin
               clip_edge(s, stage_prev[s], stage_prev_in[s], cur[i], in_now, nxt);
            end
            stage_prev[s] = cur[i];
            stage_prev_in[s] = in_now;
         end
         if (v.last) begin
            if (stage_started[s])
               clip_edge(s, stage_prev[s], stage_prev_in[s], stage_first[s],
                         is_inside(s, stage_first[s]), nxt);
            stage_started[s] = 1'b0;
            stage_prev_in[s] = 1'b0;
         end
         cur = nxt;
      end
      foreach (cur[i]) begin
         if (held_valid) begin
            o.x = held_pt.x[31:0]; o.y = held_pt.y[31:0]; o.last = 0; o.empty = 0;
            expected_vertices.insert(expected_vertices.size(), o);
         end
         held_pt = cur[i];
         held_valid = 1'b1;
      end
      if (v.last) begin
         if (held_valid) begin
            o.x = held_pt.x[31:0]; o.y = held_pt.y[31:0]; o.empty = 0;
         end else begin
            o.x = 0; o.y = 0; o.empty = 1;
         end
         o.last = 1;
         expected_vertices.insert(expected_vertices.size(), o);
         held_valid = 1'b0;
      end
   endtask

   // Driver: offers pending vertices, idling at random when allowed.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_clip(pending_vertices.pop_front());
            sent_count++;
         end
         if (pending_vertices.size() > 0 && !(idle_en && $urandom_range(99) < 34)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {pending_vertices[0].y, pending_vertices[0].x};
            req_tlast  <= pending_vertices[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure and an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_off_left <= 0;
      end else if (hold_off_req && hold_off_left == 0) begin
         hold_off_left <= 3000;
         rsp_tready <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_tready <= (hold_off_left == 1);
      end else begin
         rsp_tready <= !(idle_en && $urandom_range(99) < 34);
      end
   end

   // Monitor: compares each accepted transaction with the oldest expectation.
   always @(posedge clock) begin
      clip_out_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_count++;
         if (expected_vertices.size() == 0) begin
            $error("unexpected result transaction x=%h y=%h", rsp_tdata[31:0], rsp_tdata[63:32]);
            error_count++;
         end else begin
            e = expected_vertices.pop_front();
            if (e.empty) empty_count++;
            if (rsp_tuser !== e.empty) begin
               $error("out_empty: expected %0d, actual %0d", e.empty, rsp_tuser);
               error_count++;
            end
            if (rsp_tlast !== e.last) begin
               $error("out_last: expected %0d, actual %0d", e.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[31:0] !== e.x) begin
               $error("out_x: expected %h, actual %h", e.x, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[63:32] !== e.y) begin
               $error("out_y: expected %h, actual %h", e.y, rsp_tdata[63:32]);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (stimulus_done && expected_vertices.size() == 0 && pending_vertices.size() == 0))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic add_vertex(input logic [31:0] x, input logic [31:0] y, input logic last);
      vertex_t v;
      v.x = x; v.y = y; v.last = last;
      pending_vertices.insert(pending_vertices.size(), v);
   endtask

   // Waits for all work to drain, then a margin for the cells to settle.
   task automatic wait_drained();
      wait (pending_vertices.size() == 0 && !req_tvalid && expected_vertices.size() == 0);
      repeat (1200) @(posedge clock);
   endtask

   // One register write; valid drops for a cycle before the next write.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_X_MIN: rect_x_min = $signed(val);
         REG_X_MAX: rect_x_max = $signed(val);
         REG_Y_MIN: rect_y_min = $signed(val);
         default:   rect_y_max = $signed(val);
      endcase
      @(posedge clock);
   endtask

   task automatic set_rect(input logic [31:0] x0, input logic [31:0] x1,
         input logic [31:0] y0, input logic [31:0] y1);
      write_reg(REG_X_MIN, x0);
      write_reg(REG_X_MAX, x1);
      write_reg(REG_Y_MIN, y0);
      write_reg(REG_Y_MAX, y1);
   endtask

   // Random coordinate: mostly near the rectangle, sometimes any 32-bit value.
   function automatic logic [31:0] rand_coord();
      if ($urandom_range(9) == 0) return $urandom;
      return $signed($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
   endfunction

   task automatic random_polygons(input int n_items);
      int left;
      int n;
      left = n_items;
      while (left > 0) begin
         n = ($urandom_range(19) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 7);
         if (n > left) n = left;
         for (int i = 0; i < n; i++) add_vertex(rand_coord(), rand_coord(), i == n - 1);
         left -= n;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0; csr_index = REG_X_MIN; csr_wdata = '0;
      error_count = 0; sent_count = 0; seen_count = 0; empty_count = 0;
      idle_cycles = 0; stimulus_done = 0; idle_en = 1; hold_off_req = 0;
      rect_x_min = 64'sh8000_0000 - 64'sh1_0000_0000; rect_y_min = rect_x_min;
      rect_x_max = 64'sh7FFF_FFFF; rect_y_max = rect_x_max;
      held_valid = 0;
      for (int s = 0; s < 4; s++) begin
         stage_started[s] = 0; stage_prev_in[s] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: widest rectangle with extreme coordinates, a three-vertex polygon and a single vertex.
      add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 0);
      add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0);
      add_vertex(32'hFFFF_FFFF, 32'h0000_0000, 1);
      add_vertex(32'h0000_1234, 32'hFFFF_0000, 1);
      wait_drained();

      // Directed: unit square, a polygon crossing every boundary, a dropped
      // single vertex, a fully outside polygon and a fully inside one.
      set_rect(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
      add_vertex(32'hFFFE_0000, 32'hFFFE_0000, 0);
      add_vertex(32'h0002_0000, 32'hFFFE_8000, 0);
      add_vertex(32'h0002_4000, 32'h0002_0000, 0);
      add_vertex(32'hFFFD_0000, 32'h0001_8000, 1);
      add_vertex(32'h0005_0000, 32'h0000_0000, 1);
      add_vertex(32'h0005_0000, 32'h0005_0000, 0);
      add_vertex(32'h0006_0000, 32'h0005_0000, 0);
      add_vertex(32'h0006_0000, 32'h0006_0000, 1);
      add_vertex(32'h0000_0000, 32'h0000_0000, 0);
      add_vertex(32'h0000_8000, 32'h0000_0000, 0);
      add_vertex(32'h0000_8000, 32'h0000_8000, 1);
      wait_drained();

      // Directed: inverted rectangle always gives an empty polygon.
      set_rect(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
      add_vertex(32'h0000_0000, 32'h0000_0000, 0);
      add_vertex(32'h0000_4000, 32'h0000_0000, 1);
      wait_drained();

      // Random phase one with a long receiver hold-off.
      set_rect(32'hFFFE_0000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_8000);
      random_polygons(140);
      hold_off_req = 1;
      wait (hold_off_left > 0);
      hold_off_req = 0;
      wait_drained();

      // Random phase two without idling, then random extreme bounds, then a wider square.
      idle_en = 0;
      set_rect(32'hFFFF_8000, 32'h0000_8000, 32'h8000_0000, 32'h0000_0000);
      random_polygons(130);
      wait_drained();
      idle_en = 1;
      set_rect($urandom, $urandom, $urandom, $urandom);
      random_polygons(20);
      wait_drained();
      set_rect(32'hFFFD_0000, 32'h0003_0000, 32'hFFFD_0000, 32'h0003_0000);
      random_polygons(120);
      wait_drained();
      stimulus_done = 1;

      $display("Sent %0d vertices over seven rectangle settings; checked %0d clipped results",
               sent_count, seen_count);
      $display("including %0d empty polygons.", empty_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/prc_pkg.sv
design/prc_cell.sv
design/prc_tail.sv
design/polygon_rect_clipper.sv
tb/polygon_rect_clipper_tb.sv
